// ===== rtl/sv39ptb_pkg.sv =====
// Shared constants, types and the sequencer microprogram for the Sv39 page table builder.
package sv39ptb_pkg;

    // Sizing of the table pool and of one request.
    localparam int POOL_PAGES    = 64;
    localparam int MAX_REQ_PAGES = 64;

    localparam int POOL_IDX_W  = $clog2(POOL_PAGES);
    localparam int NFT_W       = $clog2(POOL_PAGES + 1);
    localparam int PAGES_W     = $clog2(MAX_REQ_PAGES + 1);
    localparam int ENTRIES     = 512;
    localparam int IDX_W       = 9;
    localparam int STORE_DEPTH = POOL_PAGES * ENTRIES;
    localparam int STORE_AW    = POOL_IDX_W + IDX_W;

    // Field widths of the item ports.
    localparam int VPAGE_W = 27;
    localparam int PPN_W   = 44;
    localparam int SIZE_W  = 19;
    localparam int PERM_W  = 8;
    localparam int PTE_W   = 64;
    localparam int OPAGE_W = 6;

    // Page geometry. Level offsets are byte address bits minus the page offset.
    localparam int PAGE_BYTES = 'h1000;
    localparam int PAGE_SHIFT = 12;
    localparam int PAGE_MASK  = PAGE_BYTES - 1;
    localparam int VPN2_LSB   = 30 - PAGE_SHIFT;
    localparam int VPN1_LSB   = 21 - PAGE_SHIFT;
    localparam int PTE_PPN_LSB = 10;

    localparam logic [PPN_W-1:0] POOL_BASE_RESET = 44'd524288;

    typedef enum logic [1:0] {
        MS_WRITTEN  = 2'd0,
        MS_KEPT     = 2'd1,
        MS_NO_TABLE = 2'd2,
        MS_EMPTY    = 2'd3
    } t_map_status;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_READ,
        OP_DESCEND,
        OP_LEAF
    } t_op;

    typedef enum logic [1:0] {
        A_L2,
        A_L1,
        A_L0
    } t_asel;

    typedef enum logic [1:0] {
        E_NONE,
        E_LEAF,
        E_FAIL,
        E_EMPTY
    } t_emit;

    typedef enum logic [2:0] {
        C_NONE,
        C_ALWAYS,
        C_NO_INPUT,
        C_EMPTY,
        C_FAIL,
        C_LAST
    } t_cond;

    typedef enum logic [3:0] {
        U_IDLE,
        U_CHECK,
        U_RD2,
        U_DESC2,
        U_RD1,
        U_DESC1,
        U_RD0,
        U_LEAF,
        U_EMIT,
        U_LOOP,
        U_FAIL,
        U_EMPTY
    } t_ustep;

    typedef struct packed {
        logic   accept;
        t_op    op;
        t_asel  asel;
        t_emit  emit;
        t_cond  cond;
        t_ustep target;
    } t_uword;

    // Status from the datapath back to the sequencer and the top level.
    typedef struct packed {
        logic clr_busy;
        logic empty;
        logic fail;
        logic last;
    } t_dp_stat;

    typedef struct packed {
        logic in_fire;
        logic empty;
        logic fail;
        logic last;
        logic out_free;
    } t_flags;

    typedef struct packed {
        logic [OPAGE_W-1:0] page;
        logic [IDX_W-1:0]   idx;
        logic [PTE_W-1:0]   pte;
        t_map_status        status;
        logic               last;
    } t_result;

    // Microprogram: one control word per step.
    function automatic t_uword ucode(t_ustep s);
        t_uword w;
        w = '{accept: 1'b0, op: OP_NONE, asel: A_L2, emit: E_NONE,
              cond: C_NONE, target: U_IDLE};
        unique case (s)
            U_IDLE: begin
                w.accept = 1'b1;
                w.cond   = C_NO_INPUT;
                w.target = U_IDLE;
            end
            U_CHECK: begin
                w.cond   = C_EMPTY;
                w.target = U_EMPTY;
            end
            U_RD2: begin
                w.op   = OP_READ;
                w.asel = A_L2;
            end
            U_DESC2: begin
                w.op     = OP_DESCEND;
                w.cond   = C_FAIL;
                w.target = U_FAIL;
            end
            U_RD1: begin
                w.op   = OP_READ;
                w.asel = A_L1;
            end
            U_DESC1: begin
                w.op     = OP_DESCEND;
                w.cond   = C_FAIL;
                w.target = U_FAIL;
            end
            U_RD0: begin
                w.op   = OP_READ;
                w.asel = A_L0;
            end
            U_LEAF: begin
                w.op = OP_LEAF;
            end
            U_EMIT: begin
                w.emit   = E_LEAF;
                w.cond   = C_LAST;
                w.target = U_IDLE;
            end
            U_LOOP: begin
                w.cond   = C_ALWAYS;
                w.target = U_RD2;
            end
            U_FAIL: begin
                w.emit   = E_FAIL;
                w.cond   = C_ALWAYS;
                w.target = U_IDLE;
            end
            U_EMPTY: begin
                w.emit   = E_EMPTY;
                w.cond   = C_ALWAYS;
                w.target = U_IDLE;
            end
            default: begin
                w.cond   = C_ALWAYS;
                w.target = U_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/sv39ptb_ram.sv =====
// Generic single-port RAM with registered read data.
module sv39ptb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sv39ptb_useq.sv =====
// Microcode sequencer: step counter, control word lookup and conditional jumps.
module sv39ptb_useq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sv39ptb_pkg::t_flags   i_flags,
    output sv39ptb_pkg::t_uword   o_uword,
    output logic                  o_go
);

    sv39ptb_pkg::t_ustep r_step;
    sv39ptb_pkg::t_ustep n_step;
    sv39ptb_pkg::t_uword uword;
    logic                cond_true;
    logic                go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= sv39ptb_pkg::U_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    always_comb begin
        uword = sv39ptb_pkg::ucode(r_step);

        unique case (uword.cond)
            sv39ptb_pkg::C_ALWAYS:   cond_true = 1'b1;
            sv39ptb_pkg::C_NO_INPUT: cond_true = !i_flags.in_fire;
            sv39ptb_pkg::C_EMPTY:    cond_true = i_flags.empty;
            sv39ptb_pkg::C_FAIL:     cond_true = i_flags.fail;
            sv39ptb_pkg::C_LAST:     cond_true = i_flags.last;
            default:                 cond_true = 1'b0;
        endcase

        // A step that hands over a result holds until the output register is free.
        go = !((uword.emit != sv39ptb_pkg::E_NONE) && !i_flags.out_free);

        if (!go) begin
            n_step = r_step;
        end else if (cond_true) begin
            n_step = uword.target;
        end else begin
            n_step = sv39ptb_pkg::t_ustep'(r_step + 4'd1);
        end
    end

    assign o_uword = uword;
    assign o_go    = go;

endmodule

// ===== rtl/sv39ptb_dp.sv =====
// Datapath: request registers, table store, allocator, link and leaf logic, clearing pass.
module sv39ptb_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [sv39ptb_pkg::PPN_W-1:0]      i_cfg_data,
    input  logic                               i_in_fire,
    input  logic [sv39ptb_pkg::VPAGE_W-1:0]    i_virt_page,
    input  logic [sv39ptb_pkg::PPN_W-1:0]      i_phys_page,
    input  logic [sv39ptb_pkg::SIZE_W-1:0]     i_size_bytes,
    input  logic [sv39ptb_pkg::PERM_W-1:0]     i_perm_bits,
    input  sv39ptb_pkg::t_uword                i_uword,
    input  logic                               i_go,
    output sv39ptb_pkg::t_dp_stat              o_stat,
    output sv39ptb_pkg::t_result               o_result
);

    localparam int PW  = sv39ptb_pkg::POOL_IDX_W;
    localparam int AW  = sv39ptb_pkg::STORE_AW;
    localparam int NW  = sv39ptb_pkg::NFT_W;
    localparam int GW  = sv39ptb_pkg::PAGES_W;
    localparam int QW  = sv39ptb_pkg::PPN_W;
    localparam int IW  = sv39ptb_pkg::IDX_W;
    localparam int SZW = sv39ptb_pkg::SIZE_W;

    // Configuration and allocator state.
    logic [QW-1:0] r_base;
    logic [NW-1:0] r_nft;

    // Clearing pass state.
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    // Request state.
    logic [sv39ptb_pkg::VPAGE_W-1:0] r_vp;
    logic [QW-1:0]                   r_pp;
    logic [sv39ptb_pkg::PERM_W-1:0]  r_perm;
    logic [GW-1:0]                   r_pages_left;
    logic [PW-1:0]                   r_cur;
    logic [AW-1:0]                   r_addr;

    // Staged leaf result.
    logic [PW-1:0]               r_res_page;
    logic [IW-1:0]               r_res_idx;
    logic [sv39ptb_pkg::PTE_W-1:0] r_res_pte;
    sv39ptb_pkg::t_map_status    r_res_status;

    logic [IW-1:0]  v2, v1, v0;
    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  ram_addr;
    logic           ram_we;
    logic [sv39ptb_pkg::PTE_W-1:0] ram_wdata;
    logic [sv39ptb_pkg::PTE_W-1:0] ram_rdata;

    logic           ent_v;
    logic [QW-1:0]  ent_ppn;
    logic [QW-1:0]  rel;
    logic [QW-1:0]  nft_ext;
    logic           stale;
    logic           full;
    logic           fail;
    logic [QW-1:0]  link_ppn;
    logic [sv39ptb_pkg::PTE_W-1:0] link_pte;
    logic [sv39ptb_pkg::PTE_W-1:0] leaf_pte;

    logic [SZW:0]   sz_round;
    logic [SZW-sv39ptb_pkg::PAGE_SHIFT:0] pages_raw;
    logic [GW-1:0]  pages_req;
    logic [PW+sv39ptb_pkg::OPAGE_W-1:0] page_ext;
    logic           emit_leaf;

    assign v2 = r_vp[sv39ptb_pkg::VPN2_LSB +: IW];
    assign v1 = r_vp[sv39ptb_pkg::VPN1_LSB +: IW];
    assign v0 = r_vp[IW-1:0];

    always_comb begin
        unique case (i_uword.asel)
            sv39ptb_pkg::A_L2: rd_addr = {PW'(0), v2};
            sv39ptb_pkg::A_L1: rd_addr = {r_cur, v1};
            sv39ptb_pkg::A_L0: rd_addr = {r_cur, v0};
            default:           rd_addr = r_addr;
        endcase
    end

    // Entry decode for a walk step.
    assign ent_v    = ram_rdata[0];
    assign ent_ppn  = ram_rdata[sv39ptb_pkg::PTE_PPN_LSB +: QW];
    assign rel      = ent_ppn - r_base;
    assign nft_ext  = {{(QW-NW){1'b0}}, r_nft};
    assign stale    = (rel >= nft_ext);
    assign full     = (r_nft >= NW'(sv39ptb_pkg::POOL_PAGES));
    assign fail     = ent_v ? stale : full;
    assign link_ppn = r_base + nft_ext;
    assign link_pte = {10'b0, link_ppn, 9'b0, 1'b1};
    assign leaf_pte = {10'b0, r_pp, 2'b0, r_perm};

    always_comb begin
        ram_we    = 1'b0;
        ram_wdata = link_pte;
        if (r_clr_busy) begin
            ram_addr  = r_clr_addr;
            ram_we    = 1'b1;
            ram_wdata = '0;
        end else if (i_uword.op == sv39ptb_pkg::OP_READ) begin
            ram_addr = rd_addr;
        end else begin
            ram_addr = r_addr;
            if ((i_uword.op == sv39ptb_pkg::OP_DESCEND) && !fail && !ent_v) begin
                ram_we    = 1'b1;
                ram_wdata = link_pte;
            end else if ((i_uword.op == sv39ptb_pkg::OP_LEAF) && !ent_v) begin
                ram_we    = 1'b1;
                ram_wdata = leaf_pte;
            end
        end
    end

    sv39ptb_ram #(
        .WIDTH (sv39ptb_pkg::PTE_W),
        .DEPTH (sv39ptb_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Page count of a request, rounded up and capped.
    assign sz_round  = {1'b0, i_size_bytes} + (SZW+1)'(sv39ptb_pkg::PAGE_MASK);
    assign pages_raw = sz_round[SZW:sv39ptb_pkg::PAGE_SHIFT];
    assign pages_req = (pages_raw > ($bits(pages_raw))'(sv39ptb_pkg::MAX_REQ_PAGES))
                     ? GW'(sv39ptb_pkg::MAX_REQ_PAGES) : GW'(pages_raw);

    assign emit_leaf = i_go && (i_uword.emit == sv39ptb_pkg::E_LEAF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base     <= sv39ptb_pkg::POOL_BASE_RESET;
            r_nft      <= NW'(1);
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            if (i_cfg_we) begin
                r_base <= i_cfg_data;
            end
            if (r_clr_busy) begin
                if (r_clr_addr == AW'(sv39ptb_pkg::STORE_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end else begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                end
            end
            if ((i_uword.op == sv39ptb_pkg::OP_DESCEND) && !fail && !ent_v) begin
                r_nft <= r_nft + NW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_fire) begin
            r_vp         <= i_virt_page;
            r_pp         <= i_phys_page;
            r_perm       <= i_perm_bits;
            r_pages_left <= pages_req;
        end else if (emit_leaf) begin
            r_vp         <= r_vp + 27'd1;
            r_pp         <= r_pp + 44'd1;
            r_pages_left <= r_pages_left - GW'(1);
        end
        if (i_uword.op == sv39ptb_pkg::OP_READ) begin
            r_addr <= rd_addr;
        end
        if ((i_uword.op == sv39ptb_pkg::OP_DESCEND) && !fail) begin
            r_cur <= ent_v ? rel[PW-1:0] : r_nft[PW-1:0];
        end
        if (i_uword.op == sv39ptb_pkg::OP_LEAF) begin
            r_res_page   <= r_cur;
            r_res_idx    <= v0;
            r_res_pte    <= ent_v ? ram_rdata : leaf_pte;
            r_res_status <= ent_v ? sv39ptb_pkg::MS_KEPT : sv39ptb_pkg::MS_WRITTEN;
        end
    end

    assign page_ext = {{sv39ptb_pkg::OPAGE_W{1'b0}}, r_res_page};

    always_comb begin
        o_result = '0;
        unique case (i_uword.emit)
            sv39ptb_pkg::E_LEAF: begin
                o_result.page   = page_ext[sv39ptb_pkg::OPAGE_W-1:0];
                o_result.idx    = r_res_idx;
                o_result.pte    = r_res_pte;
                o_result.status = r_res_status;
                o_result.last   = (r_pages_left == GW'(1));
            end
            sv39ptb_pkg::E_FAIL: begin
                o_result.status = sv39ptb_pkg::MS_NO_TABLE;
                o_result.last   = 1'b1;
            end
            sv39ptb_pkg::E_EMPTY: begin
                o_result.status = sv39ptb_pkg::MS_EMPTY;
                o_result.last   = 1'b1;
            end
            default: begin
                o_result.status = sv39ptb_pkg::MS_WRITTEN;
            end
        endcase
    end

    assign o_stat.clr_busy = r_clr_busy;
    assign o_stat.empty    = (r_pages_left == '0);
    assign o_stat.fail     = fail;
    assign o_stat.last     = (r_pages_left == GW'(1));

endmodule

// ===== rtl/sv39_page_table_builder.sv =====
// Top level of the Sv39 page table builder: sequencer, datapath and output register.
//
// Each accepted item asks for a run of 4 KiB virtual pages to be mapped onto
// consecutive physical pages in a three-level Sv39 table held in an on-chip
// store of table pages (pool page 0 is the root). The size is rounded up to
// whole pages and capped at the package's maximum request length. For every
// page the block reads the level 2 and level 1 entries, takes a fresh table
// page from a bump allocator when an entry is empty and links it, then reads
// the leaf entry: an empty leaf gets the physical page and permission bits,
// a leaf that is already valid is kept. One result item leaves per page,
// with the last one of a request flagged. When a table page is needed and
// the pool is used up, or a valid link points outside the allocated pages,
// one result with the out-of-table-pages status ends the request. A request
// of zero bytes gives one result with the empty status. After reset the
// store is swept to zero one entry a cycle; no item is accepted until the
// sweep ends, while configuration writes are taken at any time. Each step
// of the microprogram makes at most one access to the single port of the
// table store. Per page the sequencer reads and descends at level 2 and 1,
// reads the leaf, fills it if empty, emits the result (holding while the
// output register is full) and, but for the last page, loops back. A request
// cut short by the pool ends early. One item is worked on at a time; the
// next one is accepted once the sequencer is back at its idle step, even
// while the last result still waits in the output register.
// The pool base register may be written only while the block is idle.
module sv39_page_table_builder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sv39ptb_pkg::PPN_W-1:0]     i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [sv39ptb_pkg::VPAGE_W-1:0]   i_virt_page,
    input  logic [sv39ptb_pkg::PPN_W-1:0]     i_phys_page,
    input  logic [sv39ptb_pkg::SIZE_W-1:0]    i_size_bytes,
    input  logic [sv39ptb_pkg::PERM_W-1:0]    i_perm_bits,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [sv39ptb_pkg::OPAGE_W-1:0]   o_leaf_table_page,
    output logic [sv39ptb_pkg::IDX_W-1:0]     o_leaf_entry_index,
    output logic [sv39ptb_pkg::PTE_W-1:0]     o_leaf_pte,
    output logic [1:0]                        o_map_status,
    output logic                              o_last_of_request
);

    sv39ptb_pkg::t_uword   uword;
    sv39ptb_pkg::t_flags   flags;
    sv39ptb_pkg::t_dp_stat stat;
    sv39ptb_pkg::t_result  result;
    logic                  go;
    logic                  in_fire;
    logic                  out_free;
    logic                  out_load;

    // Output register: holds one result until the downstream side takes it.
    logic                  r_out_valid;
    sv39ptb_pkg::t_result  r_out;

    // Items are taken only at the idle step and never during the clearing sweep.
    assign o_ready  = uword.accept && !stat.clr_busy;
    assign in_fire  = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    assign out_load = (uword.emit != sv39ptb_pkg::E_NONE) && out_free;

    assign flags.in_fire  = in_fire;
    assign flags.empty    = stat.empty;
    assign flags.fail     = stat.fail;
    assign flags.last     = stat.last;
    assign flags.out_free = out_free;

    sv39ptb_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_uword (uword),
        .o_go    (go)
    );

    sv39ptb_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_fire    (in_fire),
        .i_virt_page  (i_virt_page),
        .i_phys_page  (i_phys_page),
        .i_size_bytes (i_size_bytes),
        .i_perm_bits  (i_perm_bits),
        .i_uword      (uword),
        .i_go         (go),
        .o_stat       (stat),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= result;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_leaf_table_page  = r_out.page;
    assign o_leaf_entry_index = r_out.idx;
    assign o_leaf_pte         = r_out.pte;
    assign o_map_status       = r_out.status;
    assign o_last_of_request  = r_out.last;

endmodule
